>>> src/sled_pkg.sv
// Shared types, codes and helpers for the string literal escape decoder.
package sled_pkg;

    localparam int NL_BITS  = 16;
    localparam int NL_OUT_W = 16;
    localparam int MAX_RES  = 4;
    localparam int CNT_W    = $clog2(MAX_RES + 1);
    localparam int IDX_W    = $clog2(MAX_RES);

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_UNTERM  = 3'd0;
    localparam logic [2:0] ERR_ESC_END = 3'd1;
    localparam logic [2:0] ERR_BAD_HEX = 3'd2;
    localparam logic [2:0] ERR_BAD_UNI = 3'd3;
    localparam logic [2:0] ERR_RANGE   = 3'd4;
    localparam logic [2:0] ERR_BAD_ESC = 3'd5;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_OPEN1  = 4'd1;
    localparam logic [3:0] PH_OPEN2  = 4'd2;
    localparam logic [3:0] PH_BODY   = 4'd3;
    localparam logic [3:0] PH_QUOTES = 4'd4;
    localparam logic [3:0] PH_ESC    = 4'd5;
    localparam logic [3:0] PH_HEX    = 4'd6;
    localparam logic [3:0] PH_UNI    = 4'd7;
    localparam logic [3:0] PH_OCT    = 4'd8;

    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_BSL = 8'h5C;

    localparam logic [31:0] CODE_MAX1 = 32'h0000_007F;
    localparam logic [31:0] CODE_MAX2 = 32'h0000_07FF;
    localparam logic [31:0] CODE_MAX3 = 32'h0000_FFFF;
    localparam logic [31:0] CODE_MAX4 = 32'h0010_FFFF;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] err;
    } res_t;

    // All results caused by one item
    typedef struct packed {
        logic [CNT_W-1:0]       count;
        res_t [MAX_RES-1:0]     r;
        logic [NL_OUT_W-1:0]    nl;
        logic                   consumed;
    } bundle_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    function automatic bundle_t push(bundle_t b, logic [1:0] k, logic [7:0] d, logic [2:0] e);
        bundle_t o;
        o = b;
        if (b.count < CNT_W'(MAX_RES))
        begin
            o.r[b.count[IDX_W-1:0]] = res_t'{kind: k, data: d, err: e};
            o.count = b.count + 1'b1;
        end
        return o;
    endfunction

    function automatic hex_t hex_decode(logic [7:0] c);
        hex_t h;
        h = '0;
        if (c >= "0" && c <= "9")
        begin
            h.valid = 1'b1;
            h.value = 4'(c - "0");
        end
        else if (c >= "a" && c <= "f")
        begin
            h.valid = 1'b1;
            h.value = 4'(c - "a" + 8'd10);
        end
        else if (c >= "A" && c <= "F")
        begin
            h.valid = 1'b1;
            h.value = 4'(c - "A" + 8'd10);
        end
        return h;
    endfunction

endpackage

>>> src/sled_if.sv
// Valid/ready channel interfaces for source bytes and decoded results.
interface sled_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       start_req;
    logic       at_end;

    modport source (output valid, ch, start_req, at_end, input ready);
    modport sink   (input valid, ch, start_req, at_end, output ready);
endinterface

interface sled_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [2:0]  error_code;
    logic [15:0] newline_count;
    logic        consumed;
    logic        last;

    modport source (output valid, kind, data_byte, error_code, newline_count, consumed, last,
                    input ready);
    modport sink   (input valid, kind, data_byte, error_code, newline_count, consumed, last,
                    output ready);
endinterface

>>> src/sled_core.sv
// Literal state registers and the per-byte decode step.
module sled_core import sled_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] ch,
    input  logic       start_req,
    input  logic       at_end,
    output bundle_t    bundle
);

    logic [3:0]         phase_reg, phase_next;
    logic [7:0]         quote_reg, quote_next;
    logic               multi_reg, multi_next;
    logic [1:0]         mq_reg, mq_next;
    logic [31:0]        acc_reg, acc_next;
    logic [3:0]         dc_reg, dc_next;
    logic               long_reg, long_next;
    logic [NL_BITS-1:0] nl_reg, nl_next;

    bundle_t     b;
    logic        cons;
    logic        do_body;
    hex_t        hv;
    logic [31:0] acc_shift;
    logic [3:0]  dc_inc;
    logic [31:0] v;

    always_comb
    begin
        phase_next = phase_reg;
        quote_next = quote_reg;
        multi_next = multi_reg;
        mq_next    = mq_reg;
        acc_next   = acc_reg;
        dc_next    = dc_reg;
        long_next  = long_reg;
        nl_next    = nl_reg;
        b          = '0;
        cons       = 1'b1;
        do_body    = 1'b0;
        hv         = hex_decode(ch);
        acc_shift  = {acc_reg[27:0], hv.value};
        dc_inc     = dc_reg + 4'd1;
        v          = acc_shift;

        if (at_end)
        begin
            cons = 1'b0;
            unique case (phase_reg)
                PH_OPEN1, PH_BODY:
                begin
                    b = push(b, KIND_ERROR, 8'h00, ERR_UNTERM);
                    phase_next = PH_IDLE;
                end
                PH_OPEN2:
                begin
                    b = push(b, KIND_DONE, 8'h00, ERR_NONE);
                    phase_next = PH_IDLE;
                end
                PH_QUOTES:
                begin
                    if (mq_reg != 2'd0)
                        b = push(b, KIND_DATA, quote_reg, ERR_NONE);
                    if (mq_reg >= 2'd2)
                        b = push(b, KIND_DATA, quote_reg, ERR_NONE);
                    b = push(b, KIND_ERROR, 8'h00, ERR_UNTERM);
                    phase_next = PH_IDLE;
                end
                PH_ESC:
                begin
                    b = push(b, KIND_ERROR, 8'h00, ERR_ESC_END);
                    phase_next = PH_IDLE;
                end
                PH_HEX:
                begin
                    if (dc_reg == 4'd0)
                        b = push(b, KIND_ERROR, 8'h00, ERR_BAD_HEX);
                    else
                    begin
                        b = push(b, KIND_DATA, acc_reg[7:0], ERR_NONE);
                        b = push(b, KIND_ERROR, 8'h00, ERR_UNTERM);
                    end
                    phase_next = PH_IDLE;
                end
                PH_UNI:
                begin
                    b = push(b, KIND_ERROR, 8'h00, ERR_BAD_UNI);
                    phase_next = PH_IDLE;
                end
                PH_OCT:
                begin
                    b = push(b, KIND_DATA, acc_reg[7:0], ERR_NONE);
                    b = push(b, KIND_ERROR, 8'h00, ERR_UNTERM);
                    phase_next = PH_IDLE;
                end
                default: ;
            endcase
        end
        else if (start_req)
        begin
            quote_next = ch;
            multi_next = 1'b0;
            mq_next    = 2'd0;
            acc_next   = '0;
            dc_next    = '0;
            long_next  = 1'b0;
            nl_next    = '0;
            phase_next = PH_OPEN1;
        end
        else
        begin
            unique case (phase_reg)
                PH_OPEN1:
                begin
                    if (ch == quote_reg)
                        phase_next = PH_OPEN2;
                    else
                        do_body = 1'b1;
                end
                PH_OPEN2:
                begin
                    if (ch == quote_reg)
                    begin
                        multi_next = 1'b1;
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        // empty literal: the byte belongs to whatever follows
                        cons = 1'b0;
                        b = push(b, KIND_DONE, 8'h00, ERR_NONE);
                        phase_next = PH_IDLE;
                    end
                end
                PH_BODY:
                    do_body = 1'b1;
                PH_QUOTES:
                begin
                    if (ch == quote_reg)
                    begin
                        if (mq_reg >= 2'd2)
                        begin
                            mq_next = 2'd0;
                            b = push(b, KIND_DONE, 8'h00, ERR_NONE);
                            phase_next = PH_IDLE;
                        end
                        else
                            mq_next = mq_reg + 2'd1;
                    end
                    else
                    begin
                        // release the quotes that did not close the literal
                        if (mq_reg != 2'd0)
                            b = push(b, KIND_DATA, quote_reg, ERR_NONE);
                        if (mq_reg >= 2'd2)
                            b = push(b, KIND_DATA, quote_reg, ERR_NONE);
                        mq_next = 2'd0;
                        do_body = 1'b1;
                    end
                end
                PH_ESC:
                begin
                    if (ch == "x")
                    begin
                        acc_next   = '0;
                        dc_next    = '0;
                        phase_next = PH_HEX;
                    end
                    else if (ch == "u" || ch == "U")
                    begin
                        acc_next   = '0;
                        dc_next    = '0;
                        long_next  = (ch == "U");
                        phase_next = PH_UNI;
                    end
                    else if (ch >= "0" && ch <= "7")
                    begin
                        acc_next   = {29'd0, ch[2:0]};
                        dc_next    = 4'd1;
                        phase_next = PH_OCT;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                        case (ch)
                            "n":     b = push(b, KIND_DATA, 8'h0A, ERR_NONE);
                            "r":     b = push(b, KIND_DATA, 8'h0D, ERR_NONE);
                            "t":     b = push(b, KIND_DATA, 8'h09, ERR_NONE);
                            "\\":    b = push(b, KIND_DATA, 8'h5C, ERR_NONE);
                            "'":     b = push(b, KIND_DATA, 8'h27, ERR_NONE);
                            "\"":    b = push(b, KIND_DATA, 8'h22, ERR_NONE);
                            "b":     b = push(b, KIND_DATA, 8'h08, ERR_NONE);
                            "f":     b = push(b, KIND_DATA, 8'h0C, ERR_NONE);
                            "v":     b = push(b, KIND_DATA, 8'h0B, ERR_NONE);
                            "a":     b = push(b, KIND_DATA, 8'h07, ERR_NONE);
                            default:
                            begin
                                b = push(b, KIND_ERROR, 8'h00, ERR_BAD_ESC);
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
                PH_HEX:
                begin
                    if (hv.valid)
                    begin
                        acc_next = acc_shift;
                        if (dc_reg != 4'd15)
                            dc_next = dc_inc;
                    end
                    else if (dc_reg == 4'd0)
                    begin
                        cons = 1'b0;
                        b = push(b, KIND_ERROR, 8'h00, ERR_BAD_HEX);
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        b = push(b, KIND_DATA, acc_reg[7:0], ERR_NONE);
                        do_body = 1'b1;
                    end
                end
                PH_UNI:
                begin
                    if (!hv.valid)
                    begin
                        cons = 1'b0;
                        b = push(b, KIND_ERROR, 8'h00, ERR_BAD_UNI);
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        acc_next = acc_shift;
                        dc_next  = dc_inc;
                        if (dc_inc >= (long_reg ? 4'd8 : 4'd4))
                        begin
                            phase_next = PH_BODY;
                            if (v <= CODE_MAX1)
                                b = push(b, KIND_DATA, v[7:0], ERR_NONE);
                            else if (v <= CODE_MAX2)
                            begin
                                b = push(b, KIND_DATA, {3'b110, v[10:6]}, ERR_NONE);
                                b = push(b, KIND_DATA, {2'b10, v[5:0]}, ERR_NONE);
                            end
                            else if (v <= CODE_MAX3)
                            begin
                                b = push(b, KIND_DATA, {4'b1110, v[15:12]}, ERR_NONE);
                                b = push(b, KIND_DATA, {2'b10, v[11:6]}, ERR_NONE);
                                b = push(b, KIND_DATA, {2'b10, v[5:0]}, ERR_NONE);
                            end
                            else if (v <= CODE_MAX4)
                            begin
                                b = push(b, KIND_DATA, {5'b11110, v[20:18]}, ERR_NONE);
                                b = push(b, KIND_DATA, {2'b10, v[17:12]}, ERR_NONE);
                                b = push(b, KIND_DATA, {2'b10, v[11:6]}, ERR_NONE);
                                b = push(b, KIND_DATA, {2'b10, v[5:0]}, ERR_NONE);
                            end
                            else
                            begin
                                b = push(b, KIND_ERROR, 8'h00, ERR_RANGE);
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                end
                PH_OCT:
                begin
                    if (ch >= "0" && ch <= "7")
                    begin
                        acc_next = {acc_reg[28:0], ch[2:0]};
                        dc_next  = dc_inc;
                        if (dc_inc >= 4'd3)
                        begin
                            b = push(b, KIND_DATA, {acc_reg[4:0], ch[2:0]}, ERR_NONE);
                            phase_next = PH_BODY;
                        end
                    end
                    else
                    begin
                        b = push(b, KIND_DATA, acc_reg[7:0], ERR_NONE);
                        do_body = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // plain body byte, after any prefix results above
        if (do_body)
        begin
            phase_next = PH_BODY;
            if (ch == CH_NL && nl_reg != '1)
                nl_next = nl_reg + 1'b1;
            if (ch == CH_NL && !multi_reg)
            begin
                b = push(b, KIND_ERROR, 8'h00, ERR_UNTERM);
                phase_next = PH_IDLE;
            end
            else if (ch == quote_reg)
            begin
                if (!multi_reg)
                begin
                    b = push(b, KIND_DONE, 8'h00, ERR_NONE);
                    phase_next = PH_IDLE;
                end
                else
                begin
                    mq_next    = 2'd1;
                    phase_next = PH_QUOTES;
                end
            end
            else if (ch == CH_BSL)
                phase_next = PH_ESC;
            else
                b = push(b, KIND_DATA, ch, ERR_NONE);
        end

        b.nl       = NL_OUT_W'(nl_next);
        b.consumed = cons;
        bundle     = b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            quote_reg <= '0;
            multi_reg <= 1'b0;
            mq_reg    <= '0;
            acc_reg   <= '0;
            dc_reg    <= '0;
            long_reg  <= 1'b0;
            nl_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            quote_reg <= quote_next;
            multi_reg <= multi_next;
            mq_reg    <= mq_next;
            acc_reg   <= acc_next;
            dc_reg    <= dc_next;
            long_reg  <= long_next;
            nl_reg    <= nl_next;
        end
    end

endmodule

>>> src/sled_outq.sv
// Two-deep result queue that hands out each item's results one per cycle while res.ready is high.
module sled_outq import sled_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_en,
    input  bundle_t       push_data,
    output logic          full,
    sled_out_if.source    res
);

    bundle_t           slot_mem [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        fill_reg, fill_next;
    logic [IDX_W-1:0]  idx_reg;

    bundle_t head;
    res_t    cur;
    logic    step;
    logic    pop;

    assign head = slot_mem[rd_ptr_reg];
    assign cur  = head.r[idx_reg];

    assign res.valid         = (fill_reg != 2'd0);
    assign res.kind          = cur.kind;
    assign res.data_byte     = cur.data;
    assign res.error_code    = cur.err;
    assign res.newline_count = head.nl;
    assign res.consumed      = head.consumed;
    assign res.last          = ((CNT_W'(idx_reg) + 1'b1) == head.count);

    assign step = res.valid && res.ready;
    assign pop  = step && res.last;
    assign full = (fill_reg == 2'd2);

    always_comb
    begin
        fill_next = fill_reg;
        if (push_en && !pop)
            fill_next = fill_reg + 2'd1;
        else if (pop && !push_en)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
            slot_mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push_en)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
                idx_reg    <= '0;
            end
            else if (step)
                idx_reg <= idx_reg + 1'b1;
        end
    end

endmodule

>>> src/string_literal_escape_decoder_top.sv
// Top level of the string literal escape decoder.
// An accepted item's results are registered in the result queue and follow earlier items' results.
// Throughput: one item per cycle while each gives at most one result and res.ready is high;
// an item with n results holds the result port until its last result is taken, and a two-deep
// result queue keeps input accepted meanwhile until both entries are filled.
// Reset: rst_n clears the literal state and empties the queue at once.
module string_literal_escape_decoder_top import sled_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sled_in_if.sink     src,
    sled_out_if.source  res
);

    logic    full;
    logic    fire;
    bundle_t bundle;

    assign src.ready = !full;
    assign fire      = src.valid && !full;

    sled_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .ch        (src.ch),
        .start_req (src.start_req),
        .at_end    (src.at_end),
        .bundle    (bundle)
    );

    sled_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (fire && (bundle.count != '0)),
        .push_data (bundle),
        .full      (full),
        .res       (res)
    );

endmodule

>>> src/sled_checker.sv
// Port-level assertions for the decoder, bound to the top level.
module sled_checker import sled_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  res_kind,
    input logic [7:0]  res_data_byte,
    input logic [15:0] res_newline_count,
    input logic        res_consumed,
    input logic        res_last
);

    // hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_kind) &&
                                       $stable(res_data_byte) && $stable(res_last)))
        else $error("result changed while stalled");

    // complete and error always close an item's results
    a_terminal_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_kind == KIND_DONE || res_kind == KIND_ERROR)) |-> res_last)
        else $error("terminal result not marked last");

    // the rest of an item follows straight away
    a_item_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && !res_last) |=> res_valid)
        else $error("results of an item broken off");

    // results of one item share consumed and newline count
    a_item_shared: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && !res_last) |=>
            (res_consumed == $past(res_consumed) &&
             res_newline_count == $past(res_newline_count)))
        else $error("item fields differ between its results");

endmodule

bind string_literal_escape_decoder_top sled_checker u_sled_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_kind          (res.kind),
    .res_data_byte     (res.data_byte),
    .res_newline_count (res.newline_count),
    .res_consumed      (res.consumed),
    .res_last          (res.last)
);
